### hw/rtl/wdnr_pkg.sv
// ----------------------------------------------------------------------------
// wdnr_pkg
// Shared codes, field widths and controller/datapath handshake structs for
// the weighted draw without immediate repeat block.
// ----------------------------------------------------------------------------
package wdnr_pkg;

  // field widths fixed by the interface
  localparam int ACT_W    = 7;
  localparam int TOK_W    = 8;
  localparam int LIM_W    = 8;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int LEFT_W   = 14;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ACTIVE_SLOTS   = 2'd0;
  localparam logic [1:0] REG_INITIAL_TOKENS = 2'd1;
  localparam logic [1:0] REG_REPEAT_LIMIT   = 2'd2;

  // register reset values
  localparam logic [ACT_W-1:0] ACTIVE_SLOTS_RST   = 7'd64;
  localparam logic [TOK_W-1:0] INITIAL_TOKENS_RST = 8'd1;
  localparam logic [LIM_W-1:0] REPEAT_LIMIT_RST   = 8'd12;

  // input commands
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RELOAD = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPEAT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALL_PLACED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_GAVE_UP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELOADED   = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic take_in;     // latch input word, clear total and slot counter
    logic idx_clr;     // slot counter to zero
    logic idx_inc;     // slot counter plus one
    logic clr_wr;      // write zero at slot counter
    logic reload_wr;   // write reload count at slot counter, accumulate total
    logic rd_sum;      // read slot counter, add into total
    logic rd_scan;     // read slot counter, add into prefix and test
    logic mul;         // scale fraction by total into target
    logic fin_reload;  // result: reloaded, clear draw history
    logic fin_gaveup;  // result: gave up
    logic fin_empty;   // result: all placed
    logic update;      // result: placed or repeat, update history and store
    logic out_load;    // move result into output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;    // slot counter at last active slot
    logic idx_max;     // slot counter at last slot of store
    logic gave_up;     // drawing has given up
    logic total_zero;  // no tokens left
    logic out_busy;    // output register holds a word not taken
  } ctrl_sts_t;

endpackage

### hw/rtl/wdnr_datapath.sv
// ----------------------------------------------------------------------------
// wdnr_datapath
// Token store, slot counter, sum/scan accumulators, target multiplier, draw
// history and output register.
// ----------------------------------------------------------------------------
module wdnr_datapath #(
  parameter int MAX_SLOTS   = 64,
  parameter int RANDOM_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wdnr_pkg::ctrl_cmd_t              cmd,
  output wdnr_pkg::ctrl_sts_t              sts,
  input  logic [RANDOM_BITS-1:0]           in_frac,
  input  logic [wdnr_pkg::ACT_W-1:0]       cfg_active_slots,
  input  logic [wdnr_pkg::TOK_W-1:0]       cfg_initial_tokens,
  input  logic [wdnr_pkg::LIM_W-1:0]       cfg_repeat_limit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wdnr_pkg::SLOT_W-1:0]      out_slot,
  output logic [wdnr_pkg::STATUS_W-1:0]    out_status,
  output logic [wdnr_pkg::LEFT_W-1:0]      out_left
);
  import wdnr_pkg::*;

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = (SW + 1 > ACT_W) ? SW + 1 : ACT_W;
  localparam int TW = $clog2(MAX_SLOTS * 255 + 1);
  localparam int RB = RANDOM_BITS;
  localparam int PW = RB + TW;

  // token store
  logic [TOK_W-1:0] mem [MAX_SLOTS];
  logic [TOK_W-1:0] rd_data_r;
  logic             mem_we;
  logic [SW-1:0]    mem_wa;
  logic [TOK_W-1:0] mem_wd;

  logic [SW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    rd_idx_q;
  logic             rd_sum_q, rd_scan_q;

  logic [RB-1:0]    frac_r;
  logic [TW-1:0]    total_r, total_nxt;
  logic [TW-1:0]    prefix_r, prefix_nxt;
  logic [TW-1:0]    target_r;
  logic             found_r;
  logic [SW-1:0]    slot_r;
  logic [TOK_W-1:0] cnt_r;
  logic             hit;

  logic [SW-1:0]    last_r;
  logic             last_none_r;
  logic [LIM_W-1:0] repeat_r, repeat_inc;
  logic             gave_up_r;
  logic             placed;

  logic [SW-1:0]       res_slot;
  logic [STATUS_W-1:0] res_status;
  logic [TW-1:0]       res_left;
  logic                res_load;

  logic                out_valid_r;
  logic [SW-1:0]       out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TW-1:0]       out_left_r;
  logic [SW-1:0]       res_slot_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [TW-1:0]       res_left_r;

  logic [CW-1:0]     act_ext, n_clamp, nm1_w;
  logic [SW-1:0]     nm1;
  logic              in_range;
  logic [TOK_W-1:0]  reload_val;
  logic [PW-1:0]     prod;
  logic [SW+SLOT_W-1:0] slot_ext;
  logic [TW+LEFT_W-1:0] left_ext;

  // active slot count clamped to 1..MAX_SLOTS
  always_comb begin
    act_ext = CW'(cfg_active_slots);
    if (act_ext == '0) begin
      n_clamp = CW'(1);
    end else if (act_ext > CW'(MAX_SLOTS)) begin
      n_clamp = CW'(MAX_SLOTS);
    end else begin
      n_clamp = act_ext;
    end
    nm1_w = n_clamp - CW'(1);
    nm1   = nm1_w[SW-1:0];
  end

  assign in_range   = (idx_r <= nm1);
  assign reload_val = in_range ? cfg_initial_tokens : '0;

  // slot counter
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr || cmd.take_in) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      rd_sum_q  <= 1'b0;
      rd_scan_q <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      rd_sum_q  <= cmd.rd_sum;
      rd_scan_q <= cmd.rd_scan;
    end
  end

  // store write port and registered read
  assign placed = last_none_r || (last_r != slot_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.reload_wr) begin
      mem_we = 1'b1;
      mem_wd = reload_val;
    end else if (cmd.update && placed && (cnt_r != '0)) begin
      mem_we = 1'b1;
      mem_wa = slot_r;
      mem_wd = cnt_r - TOK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[idx_r];
    rd_idx_q  <= idx_r;
  end

  // total accumulator
  always_comb begin
    total_nxt = total_r;
    if (cmd.take_in) begin
      total_nxt = '0;
    end else if (cmd.reload_wr) begin
      total_nxt = total_r + TW'(reload_val);
    end else if (rd_sum_q) begin
      total_nxt = total_r + TW'(rd_data_r);
    end
  end

  // scale target: floor(frac * total / 2^RB) + 1
  assign prod = PW'(frac_r) * PW'(total_r);

  // prefix scan, first slot reaching the target, else the last active slot
  assign prefix_nxt = prefix_r + TW'(rd_data_r);
  assign hit        = (prefix_nxt >= target_r) || (rd_idx_q == nm1);

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    if (cmd.take_in) begin
      frac_r <= in_frac;
    end
    if (cmd.mul) begin
      target_r <= prod[PW-1:RB] + TW'(1);
      prefix_r <= '0;
    end else if (rd_scan_q && !found_r) begin
      prefix_r <= prefix_nxt;
    end
    if (rd_scan_q && !found_r && hit) begin
      slot_r <= rd_idx_q;
      cnt_r  <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.mul) begin
      found_r <= 1'b0;
    end else if (rd_scan_q && hit) begin
      found_r <= 1'b1;
    end
  end

  // draw history
  assign repeat_inc = (repeat_r == '1) ? repeat_r : repeat_r + LIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_none_r <= 1'b1;
      repeat_r    <= '0;
      gave_up_r   <= 1'b0;
    end else if (cmd.fin_reload) begin
      last_none_r <= 1'b1;
      repeat_r    <= '0;
      gave_up_r   <= 1'b0;
    end else if (cmd.update) begin
      if (placed) begin
        last_none_r <= 1'b0;
        repeat_r    <= '0;
      end else begin
        repeat_r <= repeat_inc;
        if (repeat_inc >= cfg_repeat_limit) begin
          gave_up_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && placed) begin
      last_r <= slot_r;
    end
  end

  // result selection
  always_comb begin
    res_load   = 1'b1;
    res_slot   = '0;
    res_status = ST_RELOADED;
    res_left   = total_r;
    priority if (cmd.fin_reload) begin
      res_status = ST_RELOADED;
    end else if (cmd.fin_gaveup) begin
      res_status = ST_GAVE_UP;
    end else if (cmd.fin_empty) begin
      res_status = ST_ALL_PLACED;
      res_left   = '0;
    end else if (cmd.update) begin
      res_slot   = slot_r;
      res_status = placed ? ST_PLACED : ST_REPEAT;
      res_left   = placed ? total_r - TW'(1) : total_r;
    end else begin
      res_load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_slot_r   <= res_slot;
      res_status_r <= res_status;
      res_left_r   <= res_left;
    end
    if (cmd.out_load) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
      out_left_r   <= res_left_r;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign slot_ext   = {{SLOT_W{1'b0}}, out_slot_r};
  assign left_ext   = {{LEFT_W{1'b0}}, out_left_r};
  assign out_valid  = out_valid_r;
  assign out_slot   = slot_ext[SLOT_W-1:0];
  assign out_status = out_status_r;
  assign out_left   = left_ext[LEFT_W-1:0];

  // status to controller
  assign sts.idx_last   = (idx_r == nm1);
  assign sts.idx_max    = (idx_r == SW'(MAX_SLOTS - 1));
  assign sts.gave_up    = gave_up_r;
  assign sts.total_zero = (total_r == '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

### hw/rtl/wdnr_ctrl.sv
// ----------------------------------------------------------------------------
// wdnr_ctrl
// Sequencer: clearing pass after reset, reload sweep, sum pass, target
// scaling, scan pass, history update and result hand-off.
// ----------------------------------------------------------------------------
module wdnr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_ready,
  input  wdnr_pkg::ctrl_sts_t sts,
  output wdnr_pkg::ctrl_cmd_t cmd
);
  import wdnr_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_RELOAD = 12'b0000_0000_0100,
    S_RLDONE = 12'b0000_0000_1000,
    S_SUM    = 12'b0000_0001_0000,
    S_SUMW   = 12'b0000_0010_0000,
    S_CHECK  = 12'b0000_0100_0000,
    S_MUL    = 12'b0000_1000_0000,
    S_SCAN   = 12'b0001_0000_0000,
    S_SCANW  = 12'b0010_0000_0000,
    S_UPDATE = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_max) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = (in_cmd == CMD_RELOAD) ? S_RELOAD : S_SUM;
        end
      end
      S_RELOAD: begin
        cmd.reload_wr = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (sts.idx_max) begin
          state_nxt = S_RLDONE;
        end
      end
      S_RLDONE: begin
        cmd.fin_reload = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_SUM: begin
        cmd.rd_sum  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_SUMW;
        end
      end
      S_SUMW: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.gave_up) begin
          cmd.fin_gaveup = 1'b1;
          state_nxt      = S_FINISH;
        end else if (sts.total_zero) begin
          cmd.fin_empty = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_SCANW;
        end
      end
      S_SCANW: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/weighted_draw_no_repeat.sv
// ----------------------------------------------------------------------------
// weighted_draw_no_repeat
// Roulette-wheel slot draw without immediate repeat, over a store of
// per-slot token counts, with an APB register port.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tuser: cmd; tdata: random_fraction
//  out_    | master    | tuser: draw_status; tdata: chosen_slot, tokens_left
//  cfg_    | apb slave | active_slots, initial_tokens, repeat_limit
//
//  draw: a sum pass and a scan pass over the one-port token store for n
//  active slots; the sum pass only when given up or empty
//  reload: one store write per cycle
//  after reset a clearing pass zeroes the store, in_tready
//  low; register writes are taken throughout
//  a stalled out_ holds the item in its last cycle until the register frees
// ----------------------------------------------------------------------------
module weighted_draw_no_repeat #(
  parameter int MAX_SLOTS   = 64,
  parameter int RANDOM_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: random_fraction; in_tuser: cmd
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((RANDOM_BITS+7)/8)*8-1:0]       in_tdata,
  input  logic                                   in_tuser,
  // out_tdata: chosen_slot, tokens_left; out_tuser: draw_status
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [23:0]                            out_tdata,
  output logic [wdnr_pkg::STATUS_W-1:0]          out_tuser,
  // register port
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [wdnr_pkg::CFG_AW-1:0]            cfg_paddr,
  input  logic [wdnr_pkg::CFG_DW-1:0]            cfg_pwdata,
  output logic [wdnr_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);
  import wdnr_pkg::*;

  logic [ACT_W-1:0] active_slots_r;
  logic [TOK_W-1:0] initial_tokens_r;
  logic [LIM_W-1:0] repeat_limit_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  ctrl_cmd_t           cmd;
  ctrl_sts_t           sts;
  logic [SLOT_W-1:0]   out_slot;
  logic [LEFT_W-1:0]   out_left;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r   <= ACTIVE_SLOTS_RST;
      initial_tokens_r <= INITIAL_TOKENS_RST;
      repeat_limit_r   <= REPEAT_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACTIVE_SLOTS:   active_slots_r   <= cfg_pwdata[ACT_W-1:0];
        REG_INITIAL_TOKENS: initial_tokens_r <= cfg_pwdata[TOK_W-1:0];
        REG_REPEAT_LIMIT:   repeat_limit_r   <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      REG_ACTIVE_SLOTS:   cfg_prdata = CFG_DW'(active_slots_r);
      REG_INITIAL_TOKENS: cfg_prdata = CFG_DW'(initial_tokens_r);
      REG_REPEAT_LIMIT:   cfg_prdata = CFG_DW'(repeat_limit_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // sequencer
  wdnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // token store and arithmetic
  wdnr_datapath #(
    .MAX_SLOTS   (MAX_SLOTS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_frac            (in_tdata[RANDOM_BITS-1:0]),
    .cfg_active_slots   (active_slots_r),
    .cfg_initial_tokens (initial_tokens_r),
    .cfg_repeat_limit   (repeat_limit_r),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_slot           (out_slot),
    .out_status         (out_tuser),
    .out_left           (out_left)
  );

  assign out_tdata = {4'b0000, out_left, out_slot};

  // one item in flight: accepting closes the input side
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after accepting an item");

  // a result appears only after work that held the input closed
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised without a preceding work cycle");

  // only placed and repeat results name a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_PLACED && out_tuser != ST_REPEAT
      |-> out_tdata[SLOT_W-1:0] == '0)
    else $error("slot reported on a result without a draw");

endmodule
